/* src/tcsw_pkg.sv */
// Shared types, constants and the sine table function for the text character scale wave unit.
package tcsw_pkg;

    localparam int VERT_W  = 32;
    localparam int CFG_W   = 16;
    localparam int IDX_W_C = 3;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [IDX_W_C-1:0] {
        REG_SPEED     = 3'd0,
        REG_CHAR_STEP = 3'd1,
        REG_FLIP      = 3'd2,
        REG_SCALE_X   = 3'd3,
        REG_SCALE_Y   = 3'd4,
        REG_SCALE_Z   = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINE,
        S_FAC,
        S_DIV,
        S_FIX,
        S_READ,
        S_MUL,
        S_SAT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic sine_rd;
        logic div_start;
        logic fac_ld;
        logic div_step;
        logic fix;
        logic rd;
        logic mul;
        logic sat;
        logic k_inc;
        logic clr;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic k_last;
    } sts_t;

    // Quarter-wave sine in Q16 from an angle in Q30 radians (Taylor terms to power 13)
    function automatic logic [16:0] sine_q16(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] s;
        a2   = (a * a) >> 30;
        term = a;
        acc  = a;
        term = ((term * a2) >> 30) / 64'd6;
        acc  = acc - term;
        term = ((term * a2) >> 30) / 64'd20;
        acc  = acc + term;
        term = ((term * a2) >> 30) / 64'd42;
        acc  = acc - term;
        term = ((term * a2) >> 30) / 64'd72;
        acc  = acc + term;
        term = ((term * a2) >> 30) / 64'd110;
        acc  = acc - term;
        term = ((term * a2) >> 30) / 64'd156;
        acc  = acc + term;
        s    = (acc + 64'd8192) >> 14;
        if (s > 64'd65536)
        begin
            s = 64'd65536;
        end
        return s[16:0];
    endfunction

endpackage

/* src/text_char_scale_wave_unit.sv */
// Top level of the text character scale wave unit: configuration registers, controller, datapath.
//
// The unit takes one vertex word per cycle while idle and buffers up to MAX_VERTS vertices of a
// character; further vertices are dropped and flagged on tuser (overflow). The word with tlast
// closes the character: the unit then looks up the wave sine, forms the three axis factors,
// divides the three coordinate sums by the vertex count in three parallel bit-serial dividers
// (one step per sum bit, 32 + clog2(MAX_VERTS+1) steps, then a check that the step count has
// run out), fixes the centroid sign and emits every buffered vertex in arrival order, each
// through store read, multiply, round and saturate, and output word, plus any wait on m_tready.
// No input word is taken while a character is being emitted. tlast marks the final output word
// of the character. Configuration writes take effect at once and belong only to idle periods.
module text_char_scale_wave_unit #(
    parameter int MAX_VERTS    = 8,
    parameter int SINE_ENTRIES = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // time_seconds, char_index, vert_x, vert_y, vert_z
    input  logic         s_tlast,   // last_vertex
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // out_x, out_y, out_z
    output logic         m_tlast,   // last_of_char
    output logic         m_tuser,   // overflow
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import tcsw_pkg::*;

    logic signed [15:0] speed_reg;
    logic [15:0]        char_step_reg;
    logic               flip_reg;
    logic signed [15:0] scale_x_reg;
    logic signed [15:0] scale_y_reg;
    logic signed [15:0] scale_z_reg;

    cmd_t cmd;
    sts_t sts;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;

    // Hold configuration; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= 16'sd256;
            char_step_reg <= '0;
            flip_reg      <= 1'b0;
            scale_x_reg   <= 16'sd256;
            scale_y_reg   <= 16'sd256;
            scale_z_reg   <= 16'sd256;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SPEED:     speed_reg     <= cfg_data;
                REG_CHAR_STEP: char_step_reg <= cfg_data;
                REG_FLIP:      flip_reg      <= cfg_data[0];
                REG_SCALE_X:   scale_x_reg   <= cfg_data;
                REG_SCALE_Y:   scale_y_reg   <= cfg_data;
                REG_SCALE_Z:   scale_z_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tcsw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tcsw_dp #(
        .MAX_VERTS    (MAX_VERTS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .time_seconds   (s_tdata[31:0]),
        .char_index     (s_tdata[47:32]),
        .vert_x         (s_tdata[79:48]),
        .vert_y         (s_tdata[111:80]),
        .vert_z         (s_tdata[143:112]),
        .speed          (speed_reg),
        .char_step      (char_step_reg),
        .flip_direction (flip_reg),
        .scale_x        (scale_x_reg),
        .scale_y        (scale_y_reg),
        .scale_z        (scale_z_reg),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .last_of_char   (m_tlast),
        .overflow       (m_tuser)
    );

    assign m_tdata = {out_z, out_y, out_x};

endmodule

/* src/tcsw_ctrl.sv */
// Controller state machine that sequences buffering, centroid, factor and vertex output.
module tcsw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tlast,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output tcsw_pkg::cmd_t cmd,
    input  tcsw_pkg::sts_t sts
);
    import tcsw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = S_SINE;
                    end
                end
            end
            S_SINE:
            begin
                cmd.sine_rd   = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_FAC;
            end
            S_FAC:
            begin
                cmd.fac_ld = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_FIX;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (sts.k_last)
                    begin
                        cmd.clr    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a word is offered");

    a_sat_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sat |=> m_tvalid)
        else $error("result not offered after rounding");

    a_last_to_sine: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> cmd.sine_rd)
        else $error("character end did not start processing");

    a_clr_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr |=> s_tready)
        else $error("block not idle after final word");

endmodule

/* src/tcsw_dp.sv */
// Datapath: vertex store, sums, phase and sine lookup, centroid divider, scaling multipliers.
module tcsw_dp #(
    parameter int MAX_VERTS    = 8,
    parameter int SINE_ENTRIES = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcsw_pkg::cmd_t      cmd,
    output tcsw_pkg::sts_t      sts,
    input  logic [31:0]         time_seconds,
    input  logic [15:0]         char_index,
    input  logic signed [31:0]  vert_x,
    input  logic signed [31:0]  vert_y,
    input  logic signed [31:0]  vert_z,
    input  logic signed [15:0]  speed,
    input  logic [15:0]         char_step,
    input  logic                flip_direction,
    input  logic signed [15:0]  scale_x,
    input  logic signed [15:0]  scale_y,
    input  logic signed [15:0]  scale_z,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic                last_of_char,
    output logic                overflow
);
    import tcsw_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VERTS + 1);
    localparam int ADDR_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int SUM_W  = VERT_W + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int SIDX_W = $clog2(SINE_ENTRIES + 1);
    localparam int IP_W   = 14 + SIDX_W;
    localparam int FAC_W  = 26;
    localparam int C_W    = VERT_W + 1;
    localparam int P_W    = C_W + FAC_W;
    localparam int R_W    = P_W - 15;

    // Sine ROM, quarter wave plus the end point
    logic [16:0] sine_rom [SINE_ENTRIES+1];
    for (genvar g = 0; g <= SINE_ENTRIES; g++)
    begin : g_rom
        localparam logic [63:0] ANG = (64'(g) * PI_Q30) / 64'(2 * SINE_ENTRIES);
        assign sine_rom[g] = sine_q16(ANG);
    end

    logic [3*VERT_W-1:0]     mem [MAX_VERTS];
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic                    drop_reg;
    logic signed [48:0]      prod_reg;
    logic [15:0]             istep_reg;
    logic [16:0]             mag_reg;
    logic                    neg_reg;
    logic signed [FAC_W-1:0] fac_reg [3];
    logic [SUM_W-1:0]        num_reg [3];
    logic [CNT_W-1:0]        rem_reg [3];
    logic                    sneg_reg [3];
    logic [DCNT_W-1:0]       dcnt_reg;
    logic signed [C_W-1:0]   cen_reg [3];
    logic [ADDR_W-1:0]       k_reg;
    logic [3*VERT_W-1:0]     rdata_reg;
    logic signed [P_W-1:0]   mp_reg [3];
    logic signed [31:0]      res_reg [3];
    logic                    last_reg;
    logic                    ovf_reg;

    logic signed [VERT_W-1:0] vin [3];
    logic signed [15:0]       scl [3];
    logic [15:0]              tphase;
    logic [15:0]              phase;
    logic [IP_W-1:0]          iprod;
    logic [SIDX_W-1:0]        sidx;
    logic [SIDX_W-1:0]        saddr;
    logic signed [17:0]       sval;

    assign vin[0] = vert_x;
    assign vin[1] = vert_y;
    assign vin[2] = vert_z;
    assign scl[0] = scale_x;
    assign scl[1] = scale_y;
    assign scl[2] = scale_z;

    always_comb
    begin
        tphase = prod_reg[24:9];
        if (flip_direction)
        begin
            tphase = 16'(-tphase);
        end
        phase = tphase + istep_reg;
        iprod = IP_W'(phase[13:0]) * IP_W'(SINE_ENTRIES);
        sidx  = iprod[IP_W-1:14];
        saddr = phase[14] ? (SIDX_W'(SINE_ENTRIES) - sidx) : sidx;
        sval  = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    // Buffer incoming vertices, drop past capacity, and read the store for output
    always_ff @(posedge clk)
    begin
        if (cmd.load && cnt_reg != CNT_W'(MAX_VERTS))
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= {vert_z, vert_y, vert_x};
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[k_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
            k_reg    <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr)
            begin
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end
            else if (cmd.load)
            begin
                if (cnt_reg != CNT_W'(MAX_VERTS))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i] <= sum_reg[i] + SUM_W'(vin[i]);
                    end
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.div_start)
            begin
                k_reg    <= '0;
                dcnt_reg <= DCNT_W'(SUM_W);
            end
            else
            begin
                if (cmd.k_inc)
                begin
                    k_reg <= k_reg + 1'b1;
                end
                if (cmd.div_step)
                begin
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        logic [CNT_W:0]          rt;
        logic signed [35:0]      dprod;
        logic signed [R_W-1:0]   rnd;
        logic signed [R_W:0]     tot;
        if (cmd.load)
        begin
            prod_reg  <= $signed({1'b0, time_seconds}) * speed;
            istep_reg <= 16'(char_index * char_step);
        end
        if (cmd.sine_rd)
        begin
            mag_reg <= sine_rom[saddr];
            neg_reg <= phase[15];
        end
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.fac_ld)
            begin
                dprod      = ($signed({scl[i][15], scl[i]}) - 17'sd256) * sval + 36'sd128;
                fac_reg[i] <= FAC_W'(dprod >>> 8) + FAC_W'(65536);
            end
            if (cmd.div_start)
            begin
                sneg_reg[i] <= sum_reg[i][SUM_W-1];
                num_reg[i]  <= sum_reg[i][SUM_W-1] ? SUM_W'(-sum_reg[i]) : sum_reg[i];
                rem_reg[i]  <= '0;
            end
            else if (cmd.div_step)
            begin
                rt = {rem_reg[i], num_reg[i][SUM_W-1]};
                if (rt >= (CNT_W+1)'(cnt_reg))
                begin
                    rem_reg[i] <= CNT_W'(rt - (CNT_W+1)'(cnt_reg));
                    num_reg[i] <= {num_reg[i][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= CNT_W'(rt);
                    num_reg[i] <= {num_reg[i][SUM_W-2:0], 1'b0};
                end
            end
            if (cmd.fix)
            begin
                cen_reg[i] <= sneg_reg[i] ? -$signed(C_W'(num_reg[i]))
                                          : $signed(C_W'(num_reg[i]));
            end
            if (cmd.mul)
            begin
                mp_reg[i] <= ($signed({rdata_reg[i*VERT_W+VERT_W-1],
                                       rdata_reg[i*VERT_W +: VERT_W]}) - cen_reg[i])
                             * fac_reg[i];
            end
            if (cmd.sat)
            begin
                rnd = R_W'((mp_reg[i] + P_W'(32768)) >>> 16);
                tot = (R_W+1)'(rnd) + (R_W+1)'(cen_reg[i]);
                if (tot > (R_W+1)'(64'sd2147483647))
                begin
                    res_reg[i] <= 32'sh7FFFFFFF;
                end
                else if (tot < -(R_W+1)'(64'sd2147483648))
                begin
                    res_reg[i] <= 32'sh80000000;
                end
                else
                begin
                    res_reg[i] <= 32'(tot);
                end
            end
        end
        if (cmd.sat)
        begin
            last_reg <= sts.k_last;
            ovf_reg  <= drop_reg;
        end
    end

    assign sts.div_done  = (dcnt_reg == '0);
    assign sts.k_last    = ((CNT_W'(k_reg) + 1'b1) == cnt_reg);
    assign out_x         = res_reg[0];
    assign out_y         = res_reg[1];
    assign out_z         = res_reg[2];
    assign last_of_char  = last_reg;
    assign overflow      = ovf_reg;

endmodule

/* tb/tb_top.sv */
// Testbench for the text character scale wave unit, checked against a behavioral predictor.
module tb_top;

    import tcsw_pkg::*;

    localparam int MAXV = 8;
    localparam int SENT = 256;
    localparam logic [63:0] PI_CONST = 64'd3373259426;

    typedef struct packed {
        logic        last;
        logic [31:0] vz;
        logic [31:0] vy;
        logic [31:0] vx;
        logic [15:0] cidx;
        logic [31:0] tsec;
    } vert_word_t;

    typedef struct packed {
        logic        ovf;
        logic        last;
        logic [31:0] oz;
        logic [31:0] oy;
        logic [31:0] ox;
    } scaled_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;   // time_seconds, char_index, vert_x, vert_y, vert_z
    logic         s_tlast;   // last_vertex
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;   // out_x, out_y, out_z
    logic         m_tlast;   // last_of_char
    logic         m_tuser;   // overflow
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    text_char_scale_wave_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: register copies, sine table, character buffer
    logic [15:0] p_speed, p_step, p_sx, p_sy, p_sz;
    logic        p_flip;
    longint      sine_lut [0:SENT];
    longint      buf_x [MAXV], buf_y [MAXV], buf_z [MAXV];
    int          buf_n;
    longint      acc_x, acc_y, acc_z;
    logic        lost;

    vert_word_t   pending_words [$];
    scaled_word_t expected_words [$];

    int  send_idle_pct, recv_idle_pct;
    int  hold_cycles;
    bit  hold_req;
    int  mismatches;
    longint cycle_count;
    bit  stim_done;

    // Build the quarter-wave table the same way the block does: Taylor series in Q30
    task automatic build_sine_lut();
        logic [63:0] a, a2, term, acc, s;
        for (int i = 0; i <= SENT; i++)
        begin
            a    = 64'(i) * PI_CONST / 64'(2 * SENT);
            a2   = (a * a) >> 30;
            term = a;
            acc  = a;
            for (int k = 1; k <= 6; k++)
            begin
                term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) acc = acc - term;
                else acc = acc + term;
            end
            s = (acc + 64'd8192) >> 14;
            if (s > 64'd65536) s = 64'd65536;
            sine_lut[i] = longint'(s);
        end
    endtask

    function automatic longint floor_div_pow2(longint v, int n);
        return v >>> n;   // arithmetic shift floors
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint wave_factor(logic [15:0] scale_reg, longint s);
        longint d;
        d = longint'($signed(scale_reg)) - 256;
        return 65536 + floor_div_pow2(d * s + 128, 8);
    endfunction

    function automatic longint scale_about(longint v, longint c, longint f);
        return clamp32(c + floor_div_pow2((v - c) * f + 32768, 16));
    endfunction

    // Buffer one vertex; on the last vertex queue every scaled vertex of the character
    task automatic predict_char_wave(vert_word_t w);
        longint cx, cy, cz, prod, s, fx, fy, fz, mag;
        logic [15:0] phase, frac;
        int q, idx;
        scaled_word_t r;
        if (buf_n < MAXV)
        begin
            buf_x[buf_n] = longint'($signed(w.vx));
            buf_y[buf_n] = longint'($signed(w.vy));
            buf_z[buf_n] = longint'($signed(w.vz));
            acc_x += buf_x[buf_n];
            acc_y += buf_y[buf_n];
            acc_z += buf_z[buf_n];
            buf_n++;
        end
        else
        begin
            lost = 1'b1;
        end
        if (!w.last) return;
        cx = acc_x / buf_n;
        cy = acc_y / buf_n;
        cz = acc_z / buf_n;
        prod  = longint'({32'd0, w.tsec}) * longint'($signed(p_speed));
        phase = prod[24:9];
        if (p_flip) phase = 16'd0 - phase;
        phase = phase + 16'(w.cidx * p_step);
        q    = int'(phase[15:14]);
        frac = {2'b00, phase[13:0]};
        idx  = (int'(frac) * SENT) >> 14;
        mag  = (q % 2 == 1) ? sine_lut[SENT - idx] : sine_lut[idx];
        s    = (q >= 2) ? -mag : mag;
        fx = wave_factor(p_sx, s);
        fy = wave_factor(p_sy, s);
        fz = wave_factor(p_sz, s);
        for (int k = 0; k < buf_n; k++)
        begin
            r.ox   = 32'(scale_about(buf_x[k], cx, fx));
            r.oy   = 32'(scale_about(buf_y[k], cy, fy));
            r.oz   = 32'(scale_about(buf_z[k], cz, fz));
            r.last = (k == buf_n - 1);
            r.ovf  = lost;
            expected_words.push_back(r);
        end
        buf_n = 0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        lost  = 1'b0;
    endtask

    // Clock: period 4
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drive one register; only called while the block is idle
    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SPEED:     p_speed = val;
            REG_CHAR_STEP: p_step  = val;
            REG_FLIP:      p_flip  = val[0];
            REG_SCALE_X:   p_sx    = val;
            REG_SCALE_Y:   p_sy    = val;
            REG_SCALE_Z:   p_sz    = val;
            default: ;
        endcase
    endtask

    // Wait until the driver has drained and all results have come, then let the block settle
    task automatic drain();
        while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    // Queue one character of n vertices with random content
    task automatic queue_char(int n);
        vert_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.tsec = $urandom;
            w.cidx = 16'($urandom);
            w.vx   = rand_coord();
            w.vy   = rand_coord();
            w.vz   = rand_coord();
            w.last = (i == n - 1);
            pending_words.push_back(w);
        end
    endtask

    function automatic logic [15:0] rand_reg16();
        case ($urandom_range(0, 4))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 1024));
        endcase
    endfunction

    // Driver: offer the head of the pending queue, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_char_wave(pending_words.pop_front());
            end
            if ((!s_tvalid || s_tready) && pending_words.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words[0][143:0];
                s_tlast  <= pending_words[0].last;
            end
            else if (!s_tvalid || s_tready)
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, including a long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= 0;
        end
        else if (hold_req && hold_cycles == 0)
        begin
            hold_cycles <= 400;
            m_tready    <= 1'b0;
        end
        else if (hold_cycles > 1)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
        begin
            if (hold_cycles == 1 && !hold_req) hold_cycles <= 0;
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: compare every accepted word with the oldest expectation
    always @(posedge clk)
    begin
        scaled_word_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tlast, m_tdata};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output word %h", got);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%h y=%h z=%h last=%b ovf=%b,",
                                 want.ox, want.oy, want.oz, want.last, want.ovf,
                                 " got x=%h y=%h z=%h last=%b ovf=%b",
                                 got.ox, got.oy, got.oz, got.last, got.ovf);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        vert_word_t w;
        int phase_pct [3][2];
        cycle_count = 0;
        mismatches  = 0;
        stim_done   = 0;
        hold_req    = 0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        send_idle_pct = 23;
        recv_idle_pct = 62;
        buf_n = 0;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        lost  = 1'b0;
        p_speed = 16'd256;
        p_step  = 16'd0;
        p_flip  = 1'b0;
        p_sx = 16'd256;
        p_sy = 16'd256;
        p_sz = 16'd256;
        build_sine_lut();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single vertex, full character, overflow, extreme coordinates
        write_reg(REG_SCALE_X, 16'h0200);
        write_reg(REG_SCALE_Y, 16'h8000);
        write_reg(REG_SCALE_Z, 16'h7FFF);
        write_reg(REG_CHAR_STEP, 16'h4000);
        queue_char(1);
        queue_char(MAXV);
        queue_char(MAXV + 3);
        w = '{last: 1'b0, vz: 32'h8000_0000, vy: 32'h7FFF_FFFF, vx: 32'h8000_0000,
              cidx: 16'hFFFF, tsec: 32'hFFFF_FFFF};
        pending_words.push_back(w);
        w = '{last: 1'b1, vz: 32'h7FFF_FFFF, vy: 32'h8000_0000, vx: 32'h7FFF_FFFF,
              cidx: 16'd1, tsec: 32'h0001_0000};
        pending_words.push_back(w);
        drain();

        write_reg(REG_FLIP, 16'd1);
        write_reg(REG_SPEED, 16'h8000);
        queue_char(3);
        queue_char(2);
        drain();

        // Random phases: receiver-heavy idling, sender-heavy, then none
        phase_pct = '{'{23, 62}, '{62, 23}, '{0, 0}};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = phase_pct[p][0];
            recv_idle_pct = phase_pct[p][1];
            write_reg(REG_SPEED, rand_reg16());
            write_reg(REG_CHAR_STEP, 16'($urandom));
            write_reg(REG_FLIP, 16'($urandom_range(0, 1)));
            write_reg(REG_SCALE_X, rand_reg16());
            write_reg(REG_SCALE_Y, rand_reg16());
            write_reg(REG_SCALE_Z, rand_reg16());
            for (int c = 0; c < 27; c++)
            begin
                queue_char($urandom_range(0, 9) == 0 ? $urandom_range(9, 11)
                                                     : $urandom_range(1, MAXV));
            end
            if (p == 1)
            begin
                // Long receiver hold-off while words keep coming
                hold_req = 1;
                repeat (2) @(posedge clk);
                hold_req = 0;
            end
            drain();
        end

        // Restore reset values of speed, char step and flip; the scales keep their random values
        write_reg(REG_SPEED, 16'd256);
        write_reg(REG_CHAR_STEP, 16'd0);
        write_reg(REG_FLIP, 16'd0);
        queue_char(4);
        drain();

        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* text_char_scale_wave_unit.f */
src/tcsw_pkg.sv
src/tcsw_ctrl.sv
src/tcsw_dp.sv
src/text_char_scale_wave_unit.sv
tb/tb_top.sv
